### rtl/wra_pkg.sv
// Shared constants, codes and types of the wrapping range ALU.
package wra_pkg;

   localparam int VALUE_W     = 16;
   localparam int RAW_W       = 32;
   localparam int T_W         = RAW_W + 1;
   localparam int REM_W       = VALUE_W + 1;
   localparam int SPAN_EXT_W  = REM_W + 1;
   localparam int STEP_W      = $clog2(RAW_W + 1);
   localparam int AMT_W       = $clog2(RAW_W);
   localparam int OP_W        = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_LOW  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_HIGH = CSR_INDEX_W'(1);

   localparam logic signed [VALUE_W-1:0] RESET_RANGE_LOW  = VALUE_W'(1);
   localparam logic signed [VALUE_W-1:0] RESET_RANGE_HIGH = VALUE_W'(12);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 4'd0,
      OP_ADD  = 4'd1,
      OP_SUB  = 4'd2,
      OP_MUL  = 4'd3,
      OP_DIV  = 4'd4,
      OP_MOD  = 4'd5,
      OP_AND  = 4'd6,
      OP_OR   = 4'd7,
      OP_XOR  = 4'd8,
      OP_SHL  = 4'd9,
      OP_SHR  = 4'd10,
      OP_NEG  = 4'd11,
      OP_INC  = 4'd12,
      OP_DEC  = 4'd13,
      OP_CMP  = 4'd14
   } op_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_DIVW   = 7'b0000100,
      ST_WRAP   = 7'b0001000,
      ST_WRAPW  = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_SPARE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [RAW_W-1:0]  dividend;
      logic [REM_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [RAW_W-1:0] quotient;
      logic [REM_W-1:0] remainder;
   } div_rsp_type;

endpackage

### rtl/wra_if.sv
// Valid/ready channel interfaces of the wrapping range ALU.
interface wra_req_if import wra_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic signed [VALUE_W-1:0] operand;
   logic                      write_back;

   modport source (output valid, operation, operand, write_back, input ready);
   modport sink   (input valid, operation, operand, write_back, output ready);
endinterface

interface wra_rsp_if import wra_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] wrapped_value;
   logic signed [VALUE_W-1:0] previous_value;
   logic signed [RAW_W-1:0]   raw_result;
   logic                      inexact_error;
   logic                      is_less;
   logic                      is_equal;
   logic                      is_greater;

   modport source (output valid, wrapped_value, previous_value, raw_result, inexact_error,
                   is_less, is_equal, is_greater, input ready);
   modport sink   (input valid, wrapped_value, previous_value, raw_result, inexact_error,
                   is_less, is_equal, is_greater, output ready);
endinterface

interface wra_csr_if import wra_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_W-1:0]    index;
   logic signed [VALUE_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/wra_divider.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module wra_divider import wra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [RAW_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W:0]    trial;
   logic [REM_W:0]    diff;
   logic              fits;

   // The dividend enters at the top of the quotient register and shifts out
   // one bit per cycle into the partial remainder.
   assign trial = {rem_ff, quo_ff[RAW_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_in = {quo_ff[RAW_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

### rtl/wrapping_range_alu_core.sv
// Top level of the wrapping range ALU: registers, sequencer and datapath.
//
// It holds one signed value; a stored result lies in the range if not reversed.
// Each word on req_chan names an operation and an operand; the block applies it
// to the stored value, wraps the result into the range by the span
// range_high - range_low + 1, and returns one word on rsp_chan with the wrapped
// value, the value before the operation, the raw result and the flags.
// The range registers are written through csr_chan (index 0 low, 1 high),
// which is always ready; write them only while no request is in flight.
// The shared divider reduces each result into the range by the span, and for a
// divide or remainder it first forms the quotient. A zero divisor or the unused
// code skips the divider, an inexact divide skips the reduction, and so does a
// reversed range. The next request is taken in the cycle after the response is
// written, and req_chan is ready only between words. The response sits in an
// output register, so the next request is taken while the previous response
// still waits; a stalled receiver holds the block only when a second result is
// ready to be written. Reset clears both channels, sets the range to [1, 12]
// and the stored value to 1.
module wrapping_range_alu_core import wra_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   wra_req_if.sink      req_chan,
   wra_rsp_if.source    rsp_chan,
   wra_csr_if.sink      csr_chan
);

   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic signed [VALUE_W-1:0] a_ff, a_in;
   logic signed [VALUE_W-1:0] b_ff, b_in;
   logic                      wb_ff, wb_in;
   logic signed [RAW_W-1:0]   raw_ff, raw_in;
   logic signed [VALUE_W-1:0] wrapped_ff, wrapped_in;
   logic                      err_ff, err_in;
   logic                      tneg_ff, tneg_in;

   logic signed [VALUE_W-1:0] cur_ff, cur_in;
   logic signed [VALUE_W-1:0] range_low_ff, range_low_in;
   logic signed [VALUE_W-1:0] range_high_ff, range_high_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_wrapped_ff, rsp_wrapped_in;
   logic signed [VALUE_W-1:0] rsp_prev_ff, rsp_prev_in;
   logic signed [RAW_W-1:0]   rsp_raw_ff, rsp_raw_in;
   logic                      rsp_err_ff, rsp_err_in;
   logic                      rsp_lt_ff, rsp_lt_in;
   logic                      rsp_eq_ff, rsp_eq_in;
   logic                      rsp_gt_ff, rsp_gt_in;

   div_req_type               div_req;
   div_rsp_type               div_rsp;

   logic signed [RAW_W-1:0]   a32;
   logic signed [RAW_W-1:0]   b32;
   logic signed [RAW_W-1:0]   product;
   logic [AMT_W-1:0]          amt;
   logic signed [RAW_W-1:0]   raw_calc;
   logic                      is_divmod;
   logic                      is_nop;
   logic                      is_cmp;

   logic [VALUE_W-1:0]        a_mag;
   logic [VALUE_W-1:0]        b_mag;
   logic [VALUE_W-1:0]        q_mag;
   logic [VALUE_W-1:0]        r_mag;
   logic signed [RAW_W-1:0]   q_ext;
   logic signed [RAW_W-1:0]   r_ext;

   logic signed [SPAN_EXT_W-1:0] span_wide;
   logic [REM_W-1:0]          span;
   logic                      reversed;
   logic signed [T_W-1:0]     offset;
   logic [T_W-1:0]            offset_mag;
   logic [REM_W-1:0]          wrap_rem;
   logic [REM_W-1:0]          wrap_res;
   logic                      store;
   logic                      rsp_free;

   wra_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Operation datapath on the 32-bit sign-extended operands.
   assign a32     = RAW_W'(a_ff);
   assign b32     = RAW_W'(b_ff);
   assign product = a32 * b32;
   assign amt     = b_ff[AMT_W-1:0];

   always_comb begin
      raw_calc  = a32;
      is_divmod = 1'b0;
      is_nop    = 1'b0;
      is_cmp    = 1'b0;
      unique case (op_ff)
         OP_LOAD: raw_calc = b32;
         OP_ADD:  raw_calc = a32 + b32;
         OP_SUB:  raw_calc = a32 - b32;
         OP_MUL:  raw_calc = product;
         OP_DIV:  is_divmod = 1'b1;
         OP_MOD:  is_divmod = 1'b1;
         OP_AND:  raw_calc = a32 & b32;
         OP_OR:   raw_calc = a32 | b32;
         OP_XOR:  raw_calc = a32 ^ b32;
         OP_SHL:  raw_calc = a32 << amt;
         OP_SHR:  raw_calc = a32 >>> amt;
         OP_NEG:  raw_calc = -a32;
         OP_INC:  raw_calc = a32 + RAW_W'(1);
         OP_DEC:  raw_calc = a32 - RAW_W'(1);
         OP_CMP: begin
            raw_calc = b32;
            is_cmp   = 1'b1;
         end
         default: is_nop = 1'b1;
      endcase
   end

   // Magnitudes for the signed divide; quotient and remainder get their signs
   // back afterwards so that both truncate toward zero.
   assign a_mag = a_ff[VALUE_W-1] ? VALUE_W'(-a_ff) : VALUE_W'(a_ff);
   assign b_mag = b_ff[VALUE_W-1] ? VALUE_W'(-b_ff) : VALUE_W'(b_ff);
   assign q_mag = div_rsp.quotient[VALUE_W-1:0];
   assign r_mag = div_rsp.remainder[VALUE_W-1:0];
   assign q_ext = {{(RAW_W-VALUE_W){1'b0}}, q_mag};
   assign r_ext = {{(RAW_W-VALUE_W){1'b0}}, r_mag};

   // Range reduction: offset from range_low, reduced by the span with a
   // non-negative remainder. A reversed range collapses to range_low.
   assign span_wide  = SPAN_EXT_W'(range_high_ff) - SPAN_EXT_W'(range_low_ff)
                       + SPAN_EXT_W'(1);
   assign span       = span_wide[REM_W-1:0];
   assign reversed   = range_low_ff > range_high_ff;
   assign offset     = T_W'(raw_ff) - T_W'(range_low_ff);
   assign offset_mag = offset[T_W-1] ? T_W'(-offset) : T_W'(offset);
   assign wrap_rem   = div_rsp.remainder;
   assign wrap_res   = (tneg_ff && (wrap_rem != '0)) ? span - wrap_rem : wrap_rem;

   assign store    = wb_ff && !err_ff && !is_cmp && !is_nop;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      wb_in          = wb_ff;
      raw_in         = raw_ff;
      wrapped_in     = wrapped_ff;
      err_in         = err_ff;
      tneg_in        = tneg_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_wrapped_in = rsp_wrapped_ff;
      rsp_prev_in    = rsp_prev_ff;
      rsp_raw_in     = rsp_raw_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_lt_in      = rsp_lt_ff;
      rsp_eq_in      = rsp_eq_ff;
      rsp_gt_in      = rsp_gt_ff;
      div_req        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = op_type'(req_chan.operation);
               b_in     = req_chan.operand;
               wb_in    = req_chan.write_back;
               a_in     = cur_ff;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            err_in = 1'b0;
            raw_in = raw_calc;
            if (is_divmod) begin
               if (b_ff == '0) begin
                  err_in     = 1'b1;
                  raw_in     = '0;
                  wrapped_in = a_ff;
                  state_in   = ST_FINISH;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {a_mag, {(RAW_W-VALUE_W){1'b0}}};
                  div_req.divisor  = REM_W'(b_mag);
                  div_req.steps    = STEP_W'(VALUE_W);
                  state_in         = ST_DIVW;
               end
            end else if (is_nop) begin
               wrapped_in = a_ff;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_WRAP;
            end
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               if (op_ff == OP_DIV) begin
                  if (r_mag != '0) begin
                     err_in     = 1'b1;
                     raw_in     = '0;
                     wrapped_in = a_ff;
                     state_in   = ST_FINISH;
                  end else begin
                     raw_in   = (a_ff[VALUE_W-1] ^ b_ff[VALUE_W-1]) ? -q_ext : q_ext;
                     state_in = ST_WRAP;
                  end
               end else begin
                  raw_in   = a_ff[VALUE_W-1] ? -r_ext : r_ext;
                  state_in = ST_WRAP;
               end
            end
         end
         ST_WRAP: begin
            tneg_in = offset[T_W-1];
            if (reversed) begin
               wrapped_in = range_low_ff;
               state_in   = ST_FINISH;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = offset_mag[RAW_W-1:0];
               div_req.divisor  = span;
               div_req.steps    = STEP_W'(RAW_W);
               state_in         = ST_WRAPW;
            end
         end
         ST_WRAPW: begin
            if (div_rsp.done) begin
               wrapped_in = VALUE_W'(range_low_ff + wrap_res[VALUE_W-1:0]);
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_wrapped_in = wrapped_ff;
               rsp_prev_in    = a_ff;
               rsp_raw_in     = raw_ff;
               rsp_err_in     = err_ff;
               rsp_lt_in      = is_cmp && (a_ff < wrapped_ff);
               rsp_eq_in      = is_cmp && (a_ff == wrapped_ff);
               rsp_gt_in      = is_cmp && (a_ff > wrapped_ff);
               if (store) begin
                  cur_in = wrapped_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Range registers; writes to unlisted indexes are dropped.
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_RANGE_LOW:  range_low_in  = csr_chan.data;
            REG_RANGE_HIGH: range_high_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cur_ff        <= RESET_RANGE_LOW;
         range_low_ff  <= RESET_RANGE_LOW;
         range_high_ff <= RESET_RANGE_HIGH;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_ff        <= cur_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
      op_ff          <= op_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      wb_ff          <= wb_in;
      raw_ff         <= raw_in;
      wrapped_ff     <= wrapped_in;
      err_ff         <= err_in;
      tneg_ff        <= tneg_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
      rsp_prev_ff    <= rsp_prev_in;
      rsp_raw_ff     <= rsp_raw_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_lt_ff      <= rsp_lt_in;
      rsp_eq_ff      <= rsp_eq_in;
      rsp_gt_ff      <= rsp_gt_in;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.wrapped_value  = rsp_wrapped_ff;
   assign rsp_chan.previous_value = rsp_prev_ff;
   assign rsp_chan.raw_result     = rsp_raw_ff;
   assign rsp_chan.inexact_error  = rsp_err_ff;
   assign rsp_chan.is_less        = rsp_lt_ff;
   assign rsp_chan.is_equal       = rsp_eq_ff;
   assign rsp_chan.is_greater     = rsp_gt_ff;

endmodule

### tb/sv/tb_wrapping_range_alu_core.sv
// Self-checking testbench of the wrapping range ALU with a cycle-free prediction of every word.
`timescale 1ns / 100ps

module tb_wrapping_range_alu_core;
   import wra_pkg::*;

   // Operation code 15 has no name in the package; the block treats it as a no-op.
   localparam logic [OP_W-1:0] OP_UNUSED = 4'd15;

   // Ranges visited after the directed part, one pair of bounds per phase. Two more phases
   // with random narrow bounds follow the listed ones. The list covers the full 16-bit range,
   // single-value ranges at both ends, reversed ranges and ranges near both extremes.
   localparam int PHASE_COUNT = 14;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int phase_low [PHASE_COUNT] = '{-32768, 0, 32767, -32768, 5, -100, 0, -7,
                                              1000, -32768, 32000, -1, 32767, 1};
   localparam int phase_high [PHASE_COUNT] = '{32767, 0, 32767, -32768, -5, 100, 255, 3,
                                               1015, -32000, 32767, 1, -32768, 12};

   // One entry of the stimulus queue: either a request word or a range register write.
   typedef struct {
      logic                      is_csr;
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] operand;
      logic                      write_back;
      logic [CSR_INDEX_W-1:0]    csr_index;
      logic signed [VALUE_W-1:0] csr_data;
   } bus_word_type;

   // The fields of one response word.
   typedef struct packed {
      logic signed [VALUE_W-1:0] wrapped_value;
      logic signed [VALUE_W-1:0] previous_value;
      logic signed [RAW_W-1:0]   raw_result;
      logic                      inexact_error;
      logic                      is_less;
      logic                      is_equal;
      logic                      is_greater;
   } alu_result_type;

   logic clock;
   logic reset;

   wra_req_if req_bus ();
   wra_rsp_if rsp_bus ();
   wra_csr_if csr_bus ();

   wrapping_range_alu_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Words waiting to be sent, and response words predicted but not yet seen.
   bus_word_type   pending_words[$];
   alu_result_type expected_results[$];

   // The predictor's own copy of the range registers and of the stored value.
   logic signed [VALUE_W-1:0] model_low;
   logic signed [VALUE_W-1:0] model_high;
   logic signed [VALUE_W-1:0] model_value;

   // Handshakes seen at the last rising edge, read by the drivers at the falling edge.
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;

   int cycle_count    = 0;
   int mismatch_count = 0;
   int send_gap       = 0;
   int stall_left     = 0;

   always #5 clock = ~clock;

   // Sign-extends a 32-bit pattern into a wide integer.
   function automatic longint sext32(input logic [31:0] bits);
      return longint'($signed(bits));
   endfunction

   // Idle lengths: mostly none or short, now and then long. One window in five of the
   // cycle count is kept free of idling on both sides, so that words also run back to back.
   function automatic int draw_gap();
      int pick;
      if ((cycle_count / 400) % 5 == 2) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // Works out the response word for one request and updates the stored value. All
   // arithmetic is done on 64-bit integers, so sums, products and quotients are exact.
   function automatic alu_result_type alu_predict(input logic [OP_W-1:0] op,
                                                  input logic signed [VALUE_W-1:0] opnd,
                                                  input logic wb);
      alu_result_type res;
      longint      a, b, raw, wrapped, lo, hi, span, t;
      logic [31:0] a32, b32;
      int          amt;
      logic        err, store;
      a     = longint'(model_value);
      b     = longint'(opnd);
      lo    = longint'(model_low);
      hi    = longint'(model_high);
      a32   = a[31:0];
      b32   = b[31:0];
      amt   = int'(opnd[4:0]);
      raw   = a;
      err   = 1'b0;
      store = wb;
      case (op)
         OP_LOAD: raw = b;
         OP_ADD:  raw = a + b;
         OP_SUB:  raw = a - b;
         OP_MUL:  raw = a * b;
         OP_DIV: begin
            // A zero divisor or a quotient with a remainder is refused.
            if (b == 0 || (a % b) != 0) err = 1'b1;
            else raw = a / b;
         end
         OP_MOD: begin
            if (b == 0) err = 1'b1;
            else raw = a % b;
         end
         OP_AND:  raw = sext32(a32 & b32);
         OP_OR:   raw = sext32(a32 | b32);
         OP_XOR:  raw = sext32(a32 ^ b32);
         OP_SHL:  raw = sext32(a32 << amt);
         OP_SHR:  raw = sext32($signed(a32) >>> amt);
         OP_NEG:  raw = -a;
         OP_INC:  raw = a + 1;
         OP_DEC:  raw = a - 1;
         OP_CMP: begin
            raw   = b;
            store = 1'b0;
         end
         default: store = 1'b0;
      endcase
      if (err) begin
         raw     = 0;
         wrapped = a;
         store   = 1'b0;
      end else if (op == OP_UNUSED) begin
         wrapped = a;
      end else if (lo > hi) begin
         // A reversed range collapses to its low bound.
         wrapped = lo;
      end else begin
         span = hi - lo + 1;
         t    = (raw - lo) % span;
         if (t < 0) t += span;
         wrapped = lo + t;
      end
      res.wrapped_value  = wrapped[VALUE_W-1:0];
      res.previous_value = a[VALUE_W-1:0];
      res.raw_result     = raw[RAW_W-1:0];
      res.inexact_error  = err;
      res.is_less        = (op == OP_CMP) && (a < wrapped);
      res.is_equal       = (op == OP_CMP) && (a == wrapped);
      res.is_greater     = (op == OP_CMP) && (a > wrapped);
      if (store) model_value = wrapped[VALUE_W-1:0];
      return res;
   endfunction

   task automatic queue_op(input logic [OP_W-1:0] op, input int value, input logic wb);
      bus_word_type w;
      w.is_csr     = 1'b0;
      w.operation  = op;
      w.operand    = VALUE_W'(value);
      w.write_back = wb;
      w.csr_index  = REG_RANGE_LOW;
      w.csr_data   = '0;
      pending_words.push_back(w);
   endtask

   // Rising edge: note the handshakes, keep the predictor in step and check every
   // response word against the oldest prediction. The check comes before the push of a
   // new prediction, so that a response with nothing waiting is always caught.
   always @(posedge clock) begin : watch_words
      alu_result_type want;
      alu_result_type got;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_bus.valid && req_bus.ready;
      csr_taken   <= !reset && csr_bus.valid && csr_bus.ready;
      if (reset) begin
         model_low   = RESET_RANGE_LOW;
         model_high  = RESET_RANGE_HIGH;
         model_value = RESET_RANGE_LOW;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            // A range write leaves the stored value alone.
            case (csr_bus.index)
               REG_RANGE_LOW:  model_low  = csr_bus.data;
               REG_RANGE_HIGH: model_high = csr_bus.data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.wrapped_value  = rsp_bus.wrapped_value;
            got.previous_value = rsp_bus.previous_value;
            got.raw_result     = rsp_bus.raw_result;
            got.inexact_error  = rsp_bus.inexact_error;
            got.is_less        = rsp_bus.is_less;
            got.is_equal       = rsp_bus.is_equal;
            got.is_greater     = rsp_bus.is_greater;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response word with no prediction waiting: wrapped %0d prev %0d",
                           got.wrapped_value, got.previous_value);
            end else begin
               want = expected_results.pop_front();
               if (got.wrapped_value !== want.wrapped_value ||
                   got.previous_value !== want.previous_value ||
                   got.raw_result !== want.raw_result ||
                   got.inexact_error !== want.inexact_error ||
                   got.is_less !== want.is_less ||
                   got.is_equal !== want.is_equal ||
                   got.is_greater !== want.is_greater) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("expected: wrapped %0d prev %0d raw %0d err %b lt %b eq %b gt %b",
                              want.wrapped_value, want.previous_value, want.raw_result,
                              want.inexact_error, want.is_less, want.is_equal, want.is_greater);
                     $display("actual:   wrapped %0d prev %0d raw %0d err %b lt %b eq %b gt %b",
                              got.wrapped_value, got.previous_value, got.raw_result,
                              got.inexact_error, got.is_less, got.is_equal, got.is_greater);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(alu_predict(req_bus.operation, req_bus.operand,
                                                   req_bus.write_back));
      end
   end

   // Falling edge: the sender. A request word stays up until it is taken; after that a
   // random gap follows. A range write at the head of the queue waits until every
   // predicted word has come back, so the block is idle when its range changes. The valid
   // lines get exactly one assignment per edge, so a word taken and the next one raised
   // at the same edge keep valid high without a glitch.
   always @(negedge clock) begin : drive_words
      bus_word_type w;
      logic      req_up;
      logic      csr_up;
      req_up = req_bus.valid;
      csr_up = csr_bus.valid;
      if (!reset) begin
         if (req_up && req_taken) begin
            req_up   = 1'b0;
            send_gap = draw_gap();
         end
         if (csr_up && csr_taken) csr_up = 1'b0;
         if (!req_up && !csr_up) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() > 0) begin
               if (!pending_words[0].is_csr) begin
                  w = pending_words.pop_front();
                  req_bus.operation  <= w.operation;
                  req_bus.operand    <= w.operand;
                  req_bus.write_back <= w.write_back;
                  req_up = 1'b1;
               end else if (expected_results.size() == 0) begin
                  w = pending_words.pop_front();
                  csr_bus.index <= w.csr_index;
                  csr_bus.data  <= w.csr_data;
                  csr_up = 1'b1;
               end
            end
         end
      end
      req_bus.valid <= req_up;
      csr_bus.valid <= csr_up;
   end

   // Falling edge: the receiver stalls now and then, for random lengths.
   always @(negedge clock) begin : stall_results
      if (!reset) begin
         if (stall_left > 0) stall_left--;
         else if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
      end
      rsp_bus.ready <= !reset && (stall_left == 0);
   end

   // Stimulus, reset and the end of the run.
   initial begin : run_test
      bus_word_type w;
      int        lo, hi, pick, value;
      logic [OP_W-1:0] op;
      logic      wb;

      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_LOAD;
      req_bus.operand    = '0;
      req_bus.write_back = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_RANGE_LOW;
      csr_bus.data       = '0;

      // Directed words in the reset range [1, 12]: operand extremes, every operation,
      // exact and inexact division, division and remainder by zero, shifts by the
      // largest amount, compares, the unused code and report-only forms.
      queue_op(OP_LOAD, 32767, 1'b1);
      queue_op(OP_LOAD, -32768, 1'b1);
      queue_op(OP_LOAD, 5, 1'b1);
      queue_op(OP_ADD, 32767, 1'b1);
      queue_op(OP_SUB, -32768, 1'b1);
      queue_op(OP_MUL, -32768, 1'b1);
      queue_op(OP_LOAD, 6, 1'b1);
      queue_op(OP_DIV, 3, 1'b1);
      queue_op(OP_DIV, 0, 1'b1);
      queue_op(OP_LOAD, 7, 1'b1);
      queue_op(OP_DIV, 2, 1'b1);
      queue_op(OP_MOD, 0, 1'b1);
      queue_op(OP_MOD, -3, 1'b1);
      queue_op(OP_AND, -1, 1'b1);
      queue_op(OP_OR, 16'h5555, 1'b1);
      queue_op(OP_XOR, -32768, 1'b0);
      queue_op(OP_SHL, 31, 1'b0);
      queue_op(OP_SHL, 17, 1'b1);
      queue_op(OP_SHR, 1, 1'b1);
      queue_op(OP_LOAD, 9, 1'b1);
      queue_op(OP_NEG, 0, 1'b1);
      queue_op(OP_INC, 0, 1'b1);
      queue_op(OP_DEC, -1, 1'b0);
      queue_op(OP_CMP, 4, 1'b1);
      queue_op(OP_CMP, 100, 1'b1);
      queue_op(OP_CMP, -5, 1'b0);
      queue_op(OP_UNUSED, -1, 1'b1);

      // Random phases: a new range, then words with random content. Operands are drawn
      // from small values, the 16-bit extremes, values inside the range and the full
      // field, so that exact divisions and wraps across the whole span both come up.
      for (int p = 0; p < PHASE_COUNT + 2; p++) begin
         if (p < PHASE_COUNT) begin
            lo = phase_low[p];
            hi = phase_high[p];
         end else begin
            lo = int'($urandom_range(0, 400)) - 200;
            hi = lo + int'($urandom_range(0, 40));
         end
         w.is_csr     = 1'b1;
         w.operation  = OP_LOAD;
         w.operand    = '0;
         w.write_back = 1'b0;
         w.csr_index  = REG_RANGE_LOW;
         w.csr_data   = VALUE_W'(lo);
         pending_words.push_back(w);
         w.csr_index  = REG_RANGE_HIGH;
         w.csr_data   = VALUE_W'(hi);
         pending_words.push_back(w);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 99) < 3) op = OP_UNUSED;
            else op = OP_W'($urandom_range(0, 14));
            pick = $urandom_range(0, 3);
            case (pick)
               0: value = int'($urandom_range(0, 40)) - 20;
               1: begin
                  case ($urandom_range(0, 4))
                     0: value = -32768;
                     1: value = 32767;
                     2: value = 0;
                     3: value = -1;
                     default: value = 1;
                  endcase
               end
               2: value = (hi >= lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
               default: value = int'($urandom_range(0, 65535));
            endcase
            wb = ($urandom_range(0, 4) != 0);
            queue_op(op, value, wb);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || expected_results.size() > 0 ||
             req_bus.valid || csr_bus.valid)
         @(posedge clock);
      // Let any stray response word show up before the verdict.
      repeat (80) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard limit on the run, far beyond the slowest correct one.
   initial begin : watchdog
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
